### rtl/optt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optt_pkg
// Shared types and codes of the one-shot / periodic timer table.
// ----------------------------------------------------------------------------
package optt_pkg;

    // input item modes
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_STOP = 2'd1;
    localparam logic [1:0] KIND_FIRE = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    // one timer entry held by a cell
    typedef struct packed {
        logic [31:0]        id;
        logic [31:0]        first_delay;
        logic [31:0]        repeat_delay;
        logic               periodic;
        logic signed [31:0] action;
        logic [31:0]        count;
        logic [31:0]        last_time;
        logic               done;
    } t_slot;

    // per-cell control
    typedef struct packed {
        logic shift;   // take the neighbor's entry
        logic wr;      // take the broadcast entry instead
    } t_cell_ctl;

    // evaluation of the entry at the head of the chain
    typedef struct packed {
        logic  fire;
        logic  keep;
        logic  match;
        t_slot upd;
    } t_head_res;

    // one result beat
    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         status;
        logic [31:0]        timer_id;
        logic [31:0]        fire_count;
        logic signed [31:0] action_out;
        logic [31:0]        fire_ticks;
        logic               last;
    } t_result;

endpackage

### rtl/optt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optt_in_if / optt_out_if
// Valid/ready channels carrying command beats in and result beats out.
// ----------------------------------------------------------------------------
interface optt_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [31:0]        now_ticks;
    logic [31:0]        first_delay;
    logic [31:0]        repeat_delay;
    logic               repeat_enable;
    logic signed [31:0] action_in;
    logic [31:0]        stop_id;

    modport source (
        output valid, mode, now_ticks, first_delay, repeat_delay, repeat_enable,
               action_in, stop_id,
        input  ready
    );
    modport sink (
        input  valid, mode, now_ticks, first_delay, repeat_delay, repeat_enable,
               action_in, stop_id,
        output ready
    );
endinterface

interface optt_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [1:0]         status;
    logic [31:0]        timer_id;
    logic [31:0]        fire_count;
    logic signed [31:0] action_out;
    logic [31:0]        fire_ticks;
    logic               last;

    modport source (
        output valid, kind, status, timer_id, fire_count, action_out, fire_ticks, last,
        input  ready
    );
    modport sink (
        input  valid, kind, status, timer_id, fire_count, action_out, fire_ticks, last,
        output ready
    );
endinterface

### rtl/optt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optt_cell
// One timer entry of the chain: holds, shifts in its neighbor, or loads a
// broadcast entry.
// ----------------------------------------------------------------------------
module optt_cell (
    input  logic               i_clk,
    input  optt_pkg::t_cell_ctl i_ctl,
    input  optt_pkg::t_slot    i_next,
    input  optt_pkg::t_slot    i_load,
    output optt_pkg::t_slot    o_slot
);
    import optt_pkg::*;

    t_slot r_slot;

    // load broadcast entry, else shift from neighbor, else hold
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_slot <= i_load;
        end else if (i_ctl.shift) begin
            r_slot <= i_next;
        end
    end

    assign o_slot = r_slot;

endmodule

### rtl/optt_head.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optt_head
// Evaluates the entry leaving the head of the chain: firing test for a tick,
// id match for a stop, and the updated entry to write back at the tail.
// ----------------------------------------------------------------------------
module optt_head (
    input  optt_pkg::t_slot     i_slot,
    input  logic [31:0]         i_now,
    input  logic                i_is_stop,
    input  logic [31:0]         i_stop_id,
    input  logic                i_found,
    output optt_pkg::t_head_res o_res
);
    import optt_pkg::*;

    logic [31:0] w_delay;
    logic [31:0] w_due;
    logic        w_fire;
    logic        w_match;

    // deadline: first delay until the first firing, repeat delay after
    assign w_delay = (i_slot.count != 32'd0) ? i_slot.repeat_delay : i_slot.first_delay;
    assign w_due   = i_slot.last_time + w_delay;
    assign w_fire  = !i_is_stop && !i_slot.done && (i_now > w_due);
    assign w_match = i_is_stop && !i_found && (i_slot.id == i_stop_id);

    always_comb begin
        o_res       = '0;
        o_res.fire  = w_fire;
        o_res.match = w_match;
        o_res.upd   = i_slot;
        if (i_is_stop) begin
            // keep every entry; mark the first match done
            o_res.keep     = 1'b1;
            o_res.upd.done = i_slot.done | w_match;
        end else begin
            // drop done entries and one-shots on their first firing
            o_res.keep = !i_slot.done &&
                         !(w_fire && !i_slot.periodic && (i_slot.count == 32'd0));
            if (w_fire) begin
                o_res.upd.count     = i_slot.count + 32'd1;
                o_res.upd.last_time = i_now;
            end
        end
    end

endmodule

### rtl/oneshot_periodic_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oneshot_periodic_timer_table
// Ordered table of one-shot and periodic timers kept in a chain of cells.
// ----------------------------------------------------------------------------
// Usage: command beats enter on i_in (mode tick, add or stop), result beats
// leave on o_out through one output register; the last beat of a command has
// last set. Commands are taken only while no other command is in progress and
// the output register is free or being emptied.
// Add answers with the new id, or table full.
// Stop rotates the n stored entries through the head, one per cycle, marking
// the first id match done, then answers.
// Tick rotates the n stored entries the same way, dropping done entries and
// one-shots that fire, emitting one firing beat per fired entry, then the
// end-of-tick beat. Each entry passes through the single head evaluator
// (one 32-bit deadline add and compare).
// When the receiver stalls, the rotation waits until the output register can
// take the next beat; nothing is lost.
// Reset empties the table and clears the id counter; it is synchronous.
// ----------------------------------------------------------------------------
module oneshot_periodic_timer_table #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    optt_in_if.sink     i_in,
    optt_out_if.source  o_out
);
    import optt_pkg::*;

    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_STOP = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_left, n_left;
    logic [31:0]   r_next_id, n_next_id;
    logic          r_found, n_found;
    logic [31:0]   r_now, n_now;
    logic [31:0]   r_sid, n_sid;
    logic          r_ov, n_ov;
    t_result       r_out, n_out;

    t_slot         w_slot [TIMER_SLOTS];
    t_cell_ctl     w_ctl  [TIMER_SLOTS];
    t_slot         w_load;
    t_slot         w_add;
    t_head_res     w_head;
    logic          w_out_free;
    logic          w_accept;
    logic          w_step;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_idx;
    logic [CW-1:0] w_cnt_m1;

    assign w_out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_in.valid && i_in.ready;

    // entry built from an add beat
    always_comb begin
        w_add              = '0;
        w_add.id           = r_next_id;
        w_add.first_delay  = i_in.first_delay;
        w_add.repeat_delay = i_in.repeat_delay;
        w_add.periodic     = i_in.repeat_enable;
        w_add.action       = i_in.action_in;
        w_add.last_time    = i_in.now_ticks;
    end

    // evaluate the head entry
    optt_head u_head (
        .i_slot    (w_slot[0]),
        .i_now     (r_now),
        .i_is_stop (r_state == ST_STOP),
        .i_stop_id (r_sid),
        .i_found   (r_found),
        .o_res     (w_head)
    );

    // one rotation step per cycle; a tick step waits for room at the output
    assign w_step = (r_left != '0) &&
                    ((r_state == ST_STOP) || ((r_state == ST_TICK) && w_out_free));

    assign w_cnt_m1 = r_cnt - CW'(1);
    assign w_wr_en  = w_step ? w_head.keep
                             : (w_accept && (i_in.mode == MODE_ADD) &&
                                (r_cnt != CW'(TIMER_SLOTS)));
    assign w_wr_idx = w_step ? w_cnt_m1[IW-1:0] : r_cnt[IW-1:0];
    assign w_load   = w_step ? w_head.upd : w_add;

    // chain of cells, each shifting toward the head
    for (genvar k = 0; k < TIMER_SLOTS; k++) begin : g_cell
        assign w_ctl[k].shift = w_step;
        assign w_ctl[k].wr    = w_wr_en && (w_wr_idx == IW'(k));

        optt_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl[k]),
            .i_next (w_slot[(k + 1 < TIMER_SLOTS) ? k + 1 : k]),
            .i_load (w_load),
            .o_slot (w_slot[k])
        );
    end

    // sequencer and result beats
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_next_id = r_next_id;
        n_found   = r_found;
        n_now     = r_now;
        n_sid     = r_sid;
        n_ov      = r_ov && !o_out.ready;
        n_out     = r_out;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_in.mode)
                        MODE_ADD: begin
                            n_ov          = 1'b1;
                            n_out         = '0;
                            n_out.kind    = KIND_ADD;
                            n_out.last    = 1'b1;
                            if (r_cnt == CW'(TIMER_SLOTS)) begin
                                n_out.status = STAT_FULL;
                            end else begin
                                n_out.status   = STAT_OK;
                                n_out.timer_id = r_next_id;
                                n_next_id      = r_next_id + 32'd1;
                                n_cnt          = r_cnt + CW'(1);
                            end
                        end
                        MODE_STOP: begin
                            n_left  = r_cnt;
                            n_found = 1'b0;
                            n_sid   = i_in.stop_id;
                            n_state = ST_STOP;
                        end
                        MODE_TICK: begin
                            n_left  = r_cnt;
                            n_now   = i_in.now_ticks;
                            n_state = ST_TICK;
                        end
                        default: begin
                            // ignore unused mode
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (w_step) begin
                    n_left = r_left - CW'(1);
                    if (!w_head.keep) begin
                        n_cnt = w_cnt_m1;
                    end
                    if (w_head.fire) begin
                        n_ov             = 1'b1;
                        n_out            = '0;
                        n_out.kind       = KIND_FIRE;
                        n_out.status     = STAT_OK;
                        n_out.timer_id   = w_head.upd.id;
                        n_out.fire_count = w_head.upd.count;
                        n_out.action_out = w_head.upd.action;
                        n_out.fire_ticks = r_now;
                    end
                end else if ((r_left == '0) && w_out_free) begin
                    n_ov       = 1'b1;
                    n_out      = '0;
                    n_out.kind = KIND_END;
                    n_out.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_STOP: begin
                if (w_step) begin
                    n_left = r_left - CW'(1);
                    if (w_head.match) begin
                        n_found = 1'b1;
                    end
                end else if (w_out_free) begin
                    n_ov           = 1'b1;
                    n_out          = '0;
                    n_out.kind     = KIND_STOP;
                    n_out.status   = r_found ? STAT_OK : STAT_NOT_FOUND;
                    n_out.timer_id = r_sid;
                    n_out.last     = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_left    <= '0;
            r_next_id <= '0;
            r_found   <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_left    <= n_left;
            r_next_id <= n_next_id;
            r_found   <= n_found;
            r_ov      <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_now <= n_now;
        r_sid <= n_sid;
        r_out <= n_out;
    end

    assign o_out.valid      = r_ov;
    assign o_out.kind       = r_out.kind;
    assign o_out.status     = r_out.status;
    assign o_out.timer_id   = r_out.timer_id;
    assign o_out.fire_count = r_out.fire_count;
    assign o_out.action_out = r_out.action_out;
    assign o_out.fire_ticks = r_out.fire_ticks;
    assign o_out.last       = r_out.last;

endmodule

### verif/oneshot_periodic_timer_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oneshot_periodic_timer_table_test
// Self-checking bench for the one-shot / periodic timer table.
// A short table of hand-picked commands covers an empty table, the field
// extremes, wrapped deadlines, stops of unknown and already stopped timers
// and a full table. Random add, stop and tick commands follow. Each result
// beat is compared with its row's reply or the bench's behavioral table copy,
// under random gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module oneshot_periodic_timer_table_test;
    import optt_pkg::*;

    localparam int          TIMER_SLOTS   = 16;
    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 11;
    localparam int          RANDOM_ITEMS  = 100;
    localparam int          IDLE_LIMIT    = 2000;
    localparam int          SETTLE_CYCLES = 40;
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam int          SIDE_CMD      = 0;
    localparam int          SIDE_RES      = 1;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        now_ticks;
        logic [31:0]        first_delay;
        logic [31:0]        repeat_delay;
        logic               repeat_enable;
        logic signed [31:0] action_in;
        logic [31:0]        stop_id;
    } t_timer_cmd;

    // one row of the hand-picked commands; typed rows carry their reply
    typedef struct {
        t_timer_cmd cmd;
        bit         typed;
        t_result    reply;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    optt_in_if  cmd_bus ();
    optt_out_if res_bus ();

    oneshot_periodic_timer_table #(
        .TIMER_SLOTS(TIMER_SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_bus),
        .o_out  (res_bus)
    );

    // bench copy of the table, in insertion order
    t_slot       timer_tab[$];
    logic [31:0] id_counter;
    logic [31:0] sim_now;

    t_result     predicted[$];
    t_result     pending_results[$];
    t_stim_row   directed_rows[$];

    int stretch_left[2];
    bit steady[2];

    int fail_count;
    int items_sent;
    int beats_checked;
    int fires_seen;
    int full_seen;
    int missing_seen;
    int idle_cycles;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // wait before the next beat of one side; some stretches run without gaps
    function automatic int draw_wait(int side);
        if (stretch_left[side] == 0) begin
            stretch_left[side] = $urandom_range(4, 24);
            steady[side]       = ($urandom_range(0, 3) == 0);
        end
        stretch_left[side]--;
        return steady[side] ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic t_timer_cmd mk_cmd(logic [1:0] mode, logic [31:0] now_ticks,
                                          logic [31:0] first_delay,
                                          logic [31:0] repeat_delay, logic repeat_enable,
                                          logic [31:0] action_in, logic [31:0] stop_id);
        t_timer_cmd c;
        c.mode          = mode;
        c.now_ticks     = now_ticks;
        c.first_delay   = first_delay;
        c.repeat_delay  = repeat_delay;
        c.repeat_enable = repeat_enable;
        c.action_in     = action_in;
        c.stop_id       = stop_id;
        return c;
    endfunction

    function automatic t_result reply_of(logic [1:0] kind, logic [1:0] status,
                                         logic [31:0] timer_id);
        t_result r;
        r          = '0;
        r.kind     = kind;
        r.status   = status;
        r.timer_id = timer_id;
        r.last     = 1'b1;
        return r;
    endfunction

    function automatic void push_row(t_timer_cmd c, bit typed, t_result reply);
        t_stim_row row;
        row.cmd   = c;
        row.typed = typed;
        row.reply = reply;
        directed_rows.push_back(row);
    endfunction

    // apply one command to the bench table and list the result beats it causes
    function automatic void predict_cmd(t_timer_cmd c);
        t_slot       ent;
        t_result     r;
        logic [31:0] deadline;
        int          idx;
        bit          hit;
        bit          first_fire;
        predicted.delete();
        r      = '0;
        r.last = 1'b1;
        case (c.mode)
            MODE_ADD: begin
                r.kind = KIND_ADD;
                if (timer_tab.size() >= TIMER_SLOTS) begin
                    r.status = STAT_FULL;
                end else begin
                    ent              = '0;
                    ent.id           = id_counter;
                    ent.first_delay  = c.first_delay;
                    ent.repeat_delay = c.repeat_delay;
                    ent.periodic     = c.repeat_enable;
                    ent.action       = c.action_in;
                    ent.last_time    = c.now_ticks;
                    timer_tab.push_back(ent);
                    r.timer_id = id_counter;
                    id_counter = id_counter + 32'd1;
                end
                predicted.push_back(r);
            end
            MODE_STOP: begin
                r.kind     = KIND_STOP;
                r.timer_id = c.stop_id;
                r.status   = STAT_NOT_FOUND;
                hit        = 1'b0;
                // mark only the first entry with this id
                foreach (timer_tab[k]) begin
                    if (!hit && timer_tab[k].id == c.stop_id) begin
                        ent          = timer_tab[k];
                        ent.done     = 1'b1;
                        timer_tab[k] = ent;
                        hit          = 1'b1;
                        r.status     = STAT_OK;
                    end
                end
                predicted.push_back(r);
            end
            MODE_TICK: begin
                // drop entries stopped since the previous tick
                for (int k = timer_tab.size() - 1; k >= 0; k--) begin
                    if (timer_tab[k].done)
                        timer_tab.delete(k);
                end
                // walk the live entries in order, firing the expired ones
                idx = 0;
                while (idx < timer_tab.size()) begin
                    ent        = timer_tab[idx];
                    first_fire = (ent.count == 32'd0);
                    deadline   = ent.last_time +
                                 (first_fire ? ent.first_delay : ent.repeat_delay);
                    if (c.now_ticks > deadline) begin
                        ent.count     = ent.count + 32'd1;
                        ent.last_time = c.now_ticks;
                        r             = '0;
                        r.kind        = KIND_FIRE;
                        r.timer_id    = ent.id;
                        r.fire_count  = ent.count;
                        r.action_out  = ent.action;
                        r.fire_ticks  = c.now_ticks;
                        predicted.push_back(r);
                    end
                    if (c.now_ticks > deadline && first_fire && !ent.periodic) begin
                        timer_tab.delete(idx);
                    end else begin
                        timer_tab[idx] = ent;
                        idx++;
                    end
                end
                predicted.push_back(reply_of(KIND_END, STAT_OK, 32'd0));
            end
            default: begin
                // unused mode: no beat, no change
            end
        endcase
    endfunction

    // random command; fields that the mode ignores carry noise
    function automatic t_timer_cmd random_cmd();
        t_timer_cmd c;
        int         pick;
        c = mk_cmd(MODE_TICK, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                   $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            c.mode = MODE_UNUSED;
        end else if (pick < 40) begin
            if ($urandom_range(0, 19) == 0)
                sim_now = $urandom;
            else
                sim_now = sim_now + $urandom_range(0, 12);
            c.mode      = MODE_TICK;
            c.now_ticks = sim_now;
        end else if (pick < 72) begin
            sim_now       = sim_now + $urandom_range(0, 2);
            c.mode        = MODE_ADD;
            c.now_ticks   = sim_now;
            c.first_delay = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 30);
            c.repeat_delay = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 30);
        end else begin
            c.mode = MODE_STOP;
            pick   = $urandom_range(0, 99);
            if (pick < 70 && timer_tab.size() != 0)
                c.stop_id = timer_tab[$urandom_range(0, timer_tab.size() - 1)].id;
            else if (pick < 85)
                c.stop_id = id_counter - $urandom_range(0, 3);
        end
        return c;
    endfunction

    // drive one command beat, hold it until taken, then update the expectations
    task automatic send_cmd(t_timer_cmd c, bit typed, t_result reply);
        int gap;
        gap = draw_wait(SIDE_CMD);
        if (gap != 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.mode          <= c.mode;
        cmd_bus.now_ticks     <= c.now_ticks;
        cmd_bus.first_delay   <= c.first_delay;
        cmd_bus.repeat_delay  <= c.repeat_delay;
        cmd_bus.repeat_enable <= c.repeat_enable;
        cmd_bus.action_in     <= c.action_in;
        cmd_bus.stop_id       <= c.stop_id;
        do @(posedge i_clk); while (cmd_bus.ready !== 1'b1);
        predict_cmd(c);
        if (typed) begin
            pending_results.push_back(reply);
        end else begin
            foreach (predicted[k])
                pending_results.push_back(predicted[k]);
        end
        items_sent++;
    endtask

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            fail_count++;
        end
    endfunction

    // stimulus: reset, hand-picked rows, then random commands
    initial begin : stimulus
        t_timer_cmd c;
        int         random_items;
        cmd_bus.valid         <= 1'b0;
        cmd_bus.mode          <= MODE_TICK;
        cmd_bus.now_ticks     <= '0;
        cmd_bus.first_delay   <= '0;
        cmd_bus.repeat_delay  <= '0;
        cmd_bus.repeat_enable <= 1'b0;
        cmd_bus.action_in     <= '0;
        cmd_bus.stop_id       <= '0;
        i_rst_n               <= 1'b0;
        id_counter   = '0;
        sim_now      = 32'd1000;
        random_items = 0;

        // empty table, then two timers at opposite extremes
        push_row(mk_cmd(MODE_TICK, 0, 0, 0, 1'b0, 0, 0), 1'b1,
                 reply_of(KIND_END, STAT_OK, 32'd0));
        push_row(mk_cmd(MODE_STOP, 0, 0, 0, 1'b0, 0, 32'hFFFF_FFFF), 1'b1,
                 reply_of(KIND_STOP, STAT_NOT_FOUND, 32'hFFFF_FFFF));
        push_row(mk_cmd(MODE_ADD, 0, 0, 0, 1'b1, 32'h7FFF_FFFF, 0), 1'b1,
                 reply_of(KIND_ADD, STAT_OK, 32'd0));
        push_row(mk_cmd(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
                        32'h8000_0000, 32'hFFFF_FFFF), 1'b1,
                 reply_of(KIND_ADD, STAT_OK, 32'd1));
        push_row(mk_cmd(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0);
        // equal time does not fire, one past does, wrapped deadline fires last
        push_row(mk_cmd(MODE_TICK, 0, 0, 0, 1'b0, 0, 0), 1'b0, '0);
        push_row(mk_cmd(MODE_TICK, 1, 0, 0, 1'b0, 0, 0), 1'b0, '0);
        push_row(mk_cmd(MODE_TICK, 32'hFFFF_FFFF, 0, 0, 1'b0, 0, 0), 1'b0, '0);
        // one-shot is gone; stop the periodic one twice
        push_row(mk_cmd(MODE_STOP, 0, 0, 0, 1'b0, 0, 32'd1), 1'b1,
                 reply_of(KIND_STOP, STAT_NOT_FOUND, 32'd1));
        push_row(mk_cmd(MODE_STOP, 0, 0, 0, 1'b0, 0, 32'd0), 1'b1,
                 reply_of(KIND_STOP, STAT_OK, 32'd0));
        push_row(mk_cmd(MODE_STOP, 0, 0, 0, 1'b0, 0, 32'd0), 1'b1,
                 reply_of(KIND_STOP, STAT_OK, 32'd0));
        // fill the table around the stopped entry, overflow it, then tick
        for (int k = 0; k < TIMER_SLOTS - 1; k++) begin
            push_row(mk_cmd(MODE_ADD, 32'd100 + k, k, 3 * k, 1'(k % 2),
                            32'hFFFF_FF00 | k, 0), 1'b0, '0);
        end
        push_row(mk_cmd(MODE_ADD, 32'd200, 0, 0, 1'b1, 32'h1234_5678, 0), 1'b1,
                 reply_of(KIND_ADD, STAT_FULL, 32'd0));
        push_row(mk_cmd(MODE_TICK, 32'd1000, 0, 0, 1'b0, 0, 0), 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_cmd(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].reply);

        while (random_items < RANDOM_ITEMS) begin
            c = random_cmd();
            send_cmd(c, 1'b0, '0);
            if (c.mode != MODE_UNUSED)
                random_items++;
        end
        cmd_bus.valid <= 1'b0;

        // drain, then let any late beat show up
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands, checked %0d result beats.", items_sent, beats_checked);
        $display("Firings %0d, table-full replies %0d, unknown-id replies %0d.",
                 fires_seen, full_seen, missing_seen);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // result side: stall at random, check each beat against the oldest expectation
    initial begin : result_sink
        t_result got;
        t_result want;
        int      stall;
        res_bus.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = draw_wait(SIDE_RES);
            if (stall != 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (res_bus.valid !== 1'b1);
            got.kind       = res_bus.kind;
            got.status     = res_bus.status;
            got.timer_id   = res_bus.timer_id;
            got.fire_count = res_bus.fire_count;
            got.action_out = res_bus.action_out;
            got.fire_ticks = res_bus.fire_ticks;
            got.last       = res_bus.last;
            beats_checked++;
            if (got.kind == KIND_FIRE)
                fires_seen++;
            if (got.status == STAT_FULL)
                full_seen++;
            if (got.status == STAT_NOT_FOUND)
                missing_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: kind %0d, timer_id 0x%08h",
                       got.kind, got.timer_id);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("kind",       32'(want.kind),   32'(got.kind));
                compare_field("status",     32'(want.status), 32'(got.status));
                compare_field("timer_id",   want.timer_id,    got.timer_id);
                compare_field("fire_count", want.fire_count,  got.fire_count);
                compare_field("action_out", want.action_out,  got.action_out);
                compare_field("fire_ticks", want.fire_ticks,  got.fire_ticks);
                compare_field("last",       32'(want.last),   32'(got.last));
            end
        end
    end

    // watchdog: count cycles in which neither channel moves a beat
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
                (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles.", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

### files.f
rtl/optt_pkg.sv
rtl/optt_if.sv
rtl/optt_cell.sv
rtl/optt_head.sv
rtl/oneshot_periodic_timer_table.sv
verif/oneshot_periodic_timer_table_test.sv
